/* sv/rht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reassembly hole tracker package
// Sizes, field types, status codes, controller states and the command
// bundle shared by the tracker modules and interfaces.
// ----------------------------------------------------------------------------
package rht_pkg;

  // Table depth and offset width.
  localparam int MAX_HOLES   = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = 16;

  // Derived widths.
  localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam int END_W = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 1;

  typedef logic [OFFSET_BITS-1:0] addr_t;
  typedef logic [END_W-1:0]       end_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  // Item kinds.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_FRAG  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_COMPLETE   = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_SEEN       = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic update;
  } cmd_t;

endpackage : rht_pkg
`default_nettype wire

/* sv/rht_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracker input channel
// Valid/ready channel that carries one start or fragment word.
// ----------------------------------------------------------------------------
interface rht_in_if
  import rht_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  mode;
  logic [31:0] frag_offset;
  len_t  frag_length;
  logic [31:0] object_bytes;

  modport source (output valid, output mode, output frag_offset, output frag_length,
                  output object_bytes, input ready);
  modport sink   (input valid, input mode, input frag_offset, input frag_length,
                  input object_bytes, output ready);
endinterface : rht_in_if
`default_nettype wire

/* sv/rht_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel that carries one result word per input word.
// ----------------------------------------------------------------------------
interface rht_out_if
  import rht_pkg::*;
();
  logic    valid;
  logic    ready;
  status_e status;
  logic    error;
  len_t    header_length;

  modport source (output valid, output status, output error, output header_length,
                  input ready);
  modport sink   (input valid, input status, input error, input header_length,
                  output ready);
endinterface : rht_out_if
`default_nettype wire

/* sv/reassembly_hole_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted word goes through the match state, then the update state, where
// its result is registered. The controller handles one word at a time through
// the parallel match and the table update, and takes no new word before that update.
// A new word is accepted while the previous result waits in its register.
// Reset clears the hole count, object size, header length and controller;
// the hole table itself is not cleared and is read only below the count.
// ----------------------------------------------------------------------------
// Reassembly hole tracker
// Tracks the missing byte ranges of one object as fragments arrive.
// ----------------------------------------------------------------------------
module reassembly_hole_tracker
  import rht_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  rht_in_if.sink    in_i,
  rht_out_if.source out_o
);

  cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  rht_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (in_i.mode),
    .frag_offset_i   (in_i.frag_offset),
    .frag_length_i   (in_i.frag_length),
    .object_bytes_i  (in_i.object_bytes),
    .status_o        (out_o.status),
    .error_o         (out_o.error),
    .header_length_o (out_o.header_length)
  );

endmodule : reassembly_hole_tracker
`default_nettype wire

/* sv/rht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences load, match and update for one word at a time and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module rht_ctrl
  import rht_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MATCH;
      end
      S_MATCH: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
      end
      S_UPDATE: begin
        cmd_o.update = out_free;
      end
      default: ;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.update) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : rht_ctrl
`default_nettype wire

/* sv/rht_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracker datapath
// Holds the hole table, object size and header length, matches the offset
// against all holes in parallel, then trims, removes or splits the hole.
// ----------------------------------------------------------------------------
module rht_datapath
  import rht_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  input  wire         mode_i,
  input  wire  [31:0] frag_offset_i,
  input  len_t        frag_length_i,
  input  wire  [31:0] object_bytes_i,
  output status_e     status_o,
  output logic        error_o,
  output len_t        header_length_o
);

  // Latched input word.
  logic  mode_q;
  addr_t off_q;
  len_t  len_q;
  addr_t size_q;

  // Match results.
  logic  past_end_q, dup_q, empty_q, found_q;
  idx_t  idx_q;

  // Table and object state.
  addr_t first_q [MAX_HOLES];
  addr_t last_q  [MAX_HOLES];
  addr_t first_d [MAX_HOLES];
  addr_t last_d  [MAX_HOLES];
  cnt_t  count_q, count_d;
  addr_t total_q, total_d;
  len_t  header_q, header_d;

  // Result register.
  status_e status_q, status_d;
  logic    error_q, error_d;
  len_t    hdr_out_q;

  // Shared arithmetic on the latched word.
  end_t  end_w;
  end_t  lastb;
  assign end_w = end_t'(off_q) + end_t'(len_q);
  assign lastb = end_w - end_t'(1);

  // Parallel hole match with lowest-index priority.
  logic [MAX_HOLES-1:0] hit;
  idx_t                 hit_idx;
  always_comb begin
    for (int k = 0; k < MAX_HOLES; k++) begin
      hit[k] = (k < int'(count_q)) && (off_q >= first_q[k]) && (off_q <= last_q[k]);
    end
    hit_idx = '0;
    for (int k = MAX_HOLES - 1; k >= 0; k--) begin
      if (hit[k]) hit_idx = idx_t'(k);
    end
  end

  // Input latch and match registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      off_q  <= frag_offset_i[OFFSET_BITS-1:0];
      len_q  <= frag_length_i;
      size_q <= object_bytes_i[OFFSET_BITS-1:0];
    end
    if (cmd_i.match) begin
      past_end_q <= end_w > end_t'(total_q);
      dup_q      <= (off_q == '0) && (header_q != '0);
      empty_q    <= count_q == '0;
      found_q    <= |hit;
      idx_q      <= hit_idx;
    end
  end

  // Update of the table for the matched hole.
  addr_t sel_first, sel_last;
  logic  at_first, covers_last;
  assign sel_first   = first_q[idx_q];
  assign sel_last    = last_q[idx_q];
  assign at_first    = off_q == sel_first;
  assign covers_last = lastb >= end_t'(sel_last);

  always_comb begin
    first_d  = first_q;
    last_d   = last_q;
    count_d  = count_q;
    total_d  = total_q;
    header_d = header_q;
    status_d = ST_INCOMPLETE;
    error_d  = 1'b0;
    if (mode_q == MODE_START) begin
      total_d  = size_q;
      header_d = '0;
      if (size_q == '0) begin
        count_d  = '0;
        status_d = ST_COMPLETE;
      end else begin
        first_d[0] = '0;
        last_d[0]  = size_q - addr_t'(1);
        count_d    = cnt_t'(1);
      end
    end else if (past_end_q || dup_q) begin
      error_d = 1'b1;
    end else begin
      if (off_q == '0) header_d = len_q;
      if (empty_q) begin
        status_d = ST_COMPLETE;
      end else if (!found_q) begin
        status_d = ST_SEEN;
      end else if (len_q == '0) begin
        status_d = ST_INCOMPLETE;
      end else if (at_first) begin
        if (!covers_last) begin
          // Fragment covers the front of the hole.
          first_d[idx_q] = end_w[OFFSET_BITS-1:0];
        end else begin
          // Fragment covers the whole hole: close the gap behind it.
          for (int k = 0; k < MAX_HOLES - 1; k++) begin
            if (k >= int'(idx_q)) begin
              first_d[k] = first_q[k+1];
              last_d[k]  = last_q[k+1];
            end
          end
          count_d = count_q - cnt_t'(1);
          if (count_q == cnt_t'(1)) status_d = ST_COMPLETE;
        end
      end else if (covers_last) begin
        // Fragment covers the back of the hole.
        last_d[idx_q] = off_q - addr_t'(1);
      end else if (count_q >= cnt_t'(MAX_HOLES)) begin
        error_d = 1'b1;
      end else begin
        // Fragment sits inside the hole: split it and open a slot behind it.
        for (int k = 0; k < MAX_HOLES; k++) begin
          if (k > int'(idx_q) + 1) begin
            first_d[k] = first_q[k-1];
            last_d[k]  = last_q[k-1];
          end else if (k == int'(idx_q) + 1) begin
            first_d[k] = end_w[OFFSET_BITS-1:0];
            last_d[k]  = sel_last;
          end else if (k == int'(idx_q)) begin
            last_d[k]  = off_q - addr_t'(1);
          end
        end
        count_d = count_q + cnt_t'(1);
      end
    end
  end

  // Hole table storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // Object state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      header_q <= '0;
    end else if (cmd_i.update) begin
      count_q  <= count_d;
      total_q  <= total_d;
      header_q <= header_d;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_q  <= status_d;
      error_q   <= error_d;
      hdr_out_q <= header_d;
    end
  end

  assign status_o        = status_q;
  assign error_o         = error_q;
  assign header_length_o = hdr_out_q;

endmodule : rht_datapath
`default_nettype wire
